@@ rtl/assert_macros.svh @@
// Assertion macros used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/bsoc_pkg.sv @@
package bsoc_pkg;

  // Field widths.
  localparam int CODE_W  = 16;
  localparam int MAG_W   = 15;
  localparam int SCALE_W = 20;
  localparam int FB_W    = 13;
  localparam int FRAC_W  = 16;
  localparam int VQ_W    = MAG_W + SCALE_W;
  localparam int HI_W    = VQ_W - FRAC_W;
  localparam int MV_W    = 17;
  localparam int PCT_W   = 7;
  localparam int HALF_W  = 8;

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MV_PER_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK_MV = 1'b1;
  localparam logic [SCALE_W-1:0] MV_PER_CODE_RESET = 20'd170583;
  localparam logic [FB_W-1:0]    FALLBACK_MV_RESET = 13'd3690;

  localparam logic [MV_W-1:0] BATTERY_MV_MAX = 17'd90000;

  // Discharge curve, highest voltage first.
  localparam int CURVE_POINTS = 12;
  localparam int SEG_W = $clog2(CURVE_POINTS);
  localparam logic [12:0] CURVE_MV [CURVE_POINTS] = '{
    13'd4140, 13'd4100, 13'd4000, 13'd3900, 13'd3800, 13'd3700,
    13'd3600, 13'd3500, 13'd3400, 13'd3300, 13'd3200, 13'd3000
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
    7'd100, 7'd95, 7'd85, 7'd75, 7'd65, 7'd50,
    7'd35, 7'd20, 7'd10, 7'd5, 7'd2, 7'd0
  };

  // Segment geometry: voltage span fits 8 bits, percent span 4 bits.
  localparam int DMV_W      = 8;
  localparam int DP_W       = 4;
  localparam int SEG_DP_MAX = 15;
  localparam int X_W        = DMV_W + FRAC_W;
  localparam int PROD_W     = 28;
  localparam int T_W        = PROD_W - FRAC_W;

  typedef struct packed {
    logic [VQ_W-1:0] vq;
    logic            fb;
  } s1_t;

  typedef struct packed {
    logic [MV_W-1:0]  mv;
    logic [SEG_W-1:0] seg;
    logic [X_W-1:0]   x;
    logic             full;
    logic             empty;
    logic             fb;
  } s2_t;

  typedef struct packed {
    logic s3;
    logic s4;
  } interp_load_t;

endpackage

@@ rtl/bsoc_scale.sv @@
module bsoc_scale
  import bsoc_pkg::*;
(
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [CODE_W-1:0] raw_code,
  input  logic                     read_ok,
  input  logic [SCALE_W-1:0]       mv_per_code_q16,
  input  logic [FB_W-1:0]          fallback_mv,
  output s1_t                      s1
);

  logic [MAG_W-1:0] code;
  logic [VQ_W-1:0]  vq_next;

  // Clamp negative codes, then scale or take the fallback voltage.
  always_comb begin
    code = raw_code[CODE_W-1] ? '0 : raw_code[MAG_W-1:0];
    if (read_ok) begin
      vq_next = VQ_W'(code) * VQ_W'(mv_per_code_q16);
    end else begin
      vq_next = VQ_W'({fallback_mv, {FRAC_W{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1.vq <= vq_next;
      s1.fb <= ~read_ok;
    end
  end

endmodule

@@ rtl/bsoc_segment.sv @@
module bsoc_segment
  import bsoc_pkg::*;
(
  input  logic clk,
  input  logic load,
  input  s1_t  s1,
  output s2_t  s2
);

  logic [VQ_W:0]       rnd;
  logic [HI_W:0]       mv_whole;
  logic [HI_W-1:0]     hi;
  logic [SEG_W-1:0]    seg;
  logic [HI_W-1:0]     lo_mv;
  logic [HI_W-1:0]     hi_off;
  s2_t                 s2_next;

  always_comb begin
    // Round to whole millivolts and saturate.
    rnd      = {1'b0, s1.vq} + (VQ_W+1)'(1 << (FRAC_W - 1));
    mv_whole = rnd[VQ_W:FRAC_W];
    s2_next.mv = (mv_whole > (HI_W+1)'(BATTERY_MV_MAX)) ? BATTERY_MV_MAX
                                                        : mv_whole[MV_W-1:0];

    // Ends of the curve.
    hi = s1.vq[VQ_W-1:FRAC_W];
    s2_next.full  = (hi >= HI_W'(CURVE_MV[0]));
    s2_next.empty = (hi < HI_W'(CURVE_MV[CURVE_POINTS-1])) ||
                    ((hi == HI_W'(CURVE_MV[CURVE_POINTS-1])) &&
                     (s1.vq[FRAC_W-1:0] == '0));

    // Topmost segment whose lower point is at or below the voltage.
    seg = '0;
    for (int i = CURVE_POINTS - 2; i >= 0; i--) begin
      if (hi >= HI_W'(CURVE_MV[i+1])) begin
        seg = SEG_W'(i);
      end
    end
    s2_next.seg = seg;

    // Offset above the segment's lower point.
    lo_mv     = HI_W'(CURVE_MV[seg + 1'b1]);
    hi_off    = hi - lo_mv;
    s2_next.x = {hi_off[DMV_W-1:0], s1.vq[FRAC_W-1:0]};
    s2_next.fb = s1.fb;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2 <= s2_next;
    end
  end

endmodule

@@ rtl/bsoc_interp.sv @@
module bsoc_interp
  import bsoc_pkg::*;
(
  input  logic               clk,
  input  interp_load_t       load,
  input  s2_t                s2,
  output logic [MV_W-1:0]    battery_mv,
  output logic [PCT_W-1:0]   charge_percent,
  output logic [HALF_W-1:0]  charge_half_percent,
  output logic               used_fallback
);

  logic [DMV_W-1:0]  dmv2;
  logic [DP_W-1:0]   dp2;
  logic [PROD_W-1:0] prod;

  logic [MV_W-1:0]   mv3;
  logic [SEG_W-1:0]  seg3;
  logic [T_W-1:0]    t3;
  logic              full3;
  logic              empty3;
  logic              fb3;

  logic [DMV_W-1:0]  dmv3;
  logic [DP_W-1:0]   q;
  logic [PCT_W-1:0]  pct_next;
  logic [HALF_W-1:0] half_next;

  // Stage three: offset scaled by the percent span plus half the voltage span, fraction dropped.
  always_comb begin
    dmv2 = DMV_W'(CURVE_MV[s2.seg] - CURVE_MV[s2.seg + 1'b1]);
    dp2  = DP_W'(CURVE_PCT[s2.seg] - CURVE_PCT[s2.seg + 1'b1]);
    prod = PROD_W'(s2.x) * PROD_W'(dp2) + (PROD_W'(dmv2) << (FRAC_W - 1));
  end

  always_ff @(posedge clk) begin
    if (load.s3) begin
      mv3    <= s2.mv;
      seg3   <= s2.seg;
      t3     <= prod[PROD_W-1:FRAC_W];
      full3  <= s2.full;
      empty3 <= s2.empty;
      fb3    <= s2.fb;
    end
  end

  // Stage four: quotient by the segment span through a row of compares.
  always_comb begin
    dmv3 = DMV_W'(CURVE_MV[seg3] - CURVE_MV[seg3 + 1'b1]);
    q = '0;
    for (int k = 1; k <= SEG_DP_MAX; k++) begin
      if (t3 >= T_W'(k) * T_W'(dmv3)) begin
        q = DP_W'(k);
      end
    end
    if (full3) begin
      pct_next = CURVE_PCT[0];
    end else if (empty3) begin
      pct_next = CURVE_PCT[CURVE_POINTS-1];
    end else begin
      pct_next = CURVE_PCT[seg3 + 1'b1] + PCT_W'(q);
    end
    half_next = (pct_next >= 7'd100) ? 8'd200 : {pct_next, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (load.s4) begin
      battery_mv          <= mv3;
      charge_percent      <= pct_next;
      charge_half_percent <= half_next;
      used_fallback       <= fb3;
    end
  end

endmodule

@@ rtl/battery_adc_to_charge_percent_core.sv @@
// Channel   Handshake                    Payload
// sample    sample_valid / sample_stall  raw_code, read_ok
// result    result_valid / result_stall  battery_mv, charge_percent,
//                                        charge_half_percent, used_fallback
// config    cfg_write_en                 cfg_index, cfg_data
//
// Four register stages (scale multiply, segment search, interpolation
// multiply, quotient compare) carry each sample to its result in that order.
// One sample can be taken every cycle while sample_stall is low.
// Reset empties the pipeline and restores both configuration registers.
// A stalled result holds in the output stage; empty stages ahead of it still
// fill, and sample_stall rises only when every stage is occupied.
module battery_adc_to_charge_percent_core
  import bsoc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic signed [CODE_W-1:0] raw_code,
  input  logic                     read_ok,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [MV_W-1:0]          battery_mv,
  output logic [PCT_W-1:0]         charge_percent,
  output logic [HALF_W-1:0]        charge_half_percent,
  output logic                     used_fallback,
  input  logic                     cfg_write_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [SCALE_W-1:0]       cfg_data
);

`include "assert_macros.svh"

  logic [SCALE_W-1:0] mv_per_code_q16;
  logic [FB_W-1:0]    fallback_mv;

  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4;
  interp_load_t interp_load;
  s1_t s1;
  s2_t s2;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mv_per_code_q16 <= MV_PER_CODE_RESET;
      fallback_mv     <= FALLBACK_MV_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MV_PER_CODE: mv_per_code_q16 <= cfg_data;
        REG_FALLBACK_MV: fallback_mv     <= cfg_data[FB_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    ready4 = !v4 || !result_stall;
    ready3 = !v3 || ready4;
    ready2 = !v2 || ready3;
    ready1 = !v1 || ready2;
    interp_load.s3 = ready3;
    interp_load.s4 = ready4;
  end

  assign sample_stall = !ready1;
  assign result_valid = v4;

  // Valid bits that travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) v1 <= sample_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
      if (ready4) v4 <= v3;
    end
  end

  bsoc_scale u_scale (
    .clk             (clk),
    .load            (ready1),
    .raw_code        (raw_code),
    .read_ok         (read_ok),
    .mv_per_code_q16 (mv_per_code_q16),
    .fallback_mv     (fallback_mv),
    .s1              (s1)
  );

  bsoc_segment u_segment (
    .clk  (clk),
    .load (ready2),
    .s1   (s1),
    .s2   (s2)
  );

  bsoc_interp u_interp (
    .clk                 (clk),
    .load                (interp_load),
    .s2                  (s2),
    .battery_mv          (battery_mv),
    .charge_percent      (charge_percent),
    .charge_half_percent (charge_half_percent),
    .used_fallback       (used_fallback)
  );

  // An accepted transaction occupies the first stage on the next cycle.
  `ASSERT_CLK_RST(a_accept_fills, clk, rst, (sample_valid && !sample_stall) |=> v1, "accepted sample lost")
  // A taken result with nothing behind it leaves the output empty.
  `ASSERT_CLK_RST(a_no_invent, clk, rst, (v4 && !result_stall && !v3) |=> !result_valid, "result repeated")
  // Fallback voltages come from a 13-bit register.
  `ASSERT_CLK_RST(a_fb_range, clk, rst, (result_valid && used_fallback) |-> (battery_mv <= 17'd8191), "fallback voltage out of range")
  // Percent never passes full charge, and half units track it.
  `ASSERT_CLK_RST(a_pct_range, clk, rst, result_valid |-> ((charge_percent <= 7'd100) && (charge_half_percent == ((charge_percent == 7'd100) ? 8'd200 : {charge_percent, 1'b0}))), "charge out of range")

endmodule
